// File: sv/assert_macros.svh
// Assertion macros used by the checker module of the flash segment ring manager.
// Depends on nothing; take it in with a bare include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define FSRM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication from cond to prop, named for rules that concern a stalled transfer.
`define FSRM_ASSERT_HOLD(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// File: sv/fsrm_pkg.sv
// Shared types and constants of the flash segment ring manager.
// No dependencies; used by the controller, datapath, top level and checker.
package fsrm_pkg;

   localparam int STATUS_W    = 2;
   localparam int ADDR_W      = 18;
   localparam int SEG_OUT_W   = 6;
   localparam int SERIES_ID_W = 6;
   localparam int TIME_W      = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int COUNT_W     = 4;
   localparam int HINT_BLK_W  = 6;   // hint every 64 blocks
   localparam int PCT_W       = 7;

   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RECLAIM = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BUSY    = 2'd2;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_GC    = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENT_COUNT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERASE_QUOTA     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUOTA_WINDOW_MS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HINT_PERIOD_MS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WARN_PERCENT    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUSY_PERCENT    = 3'd5;

   localparam logic [6:0]  RST_SEGMENT_COUNT   = 7'd64;
   localparam logic [3:0]  RST_ERASE_QUOTA     = 4'd2;
   localparam logic [15:0] RST_QUOTA_WINDOW_MS = 16'd1000;
   localparam logic [15:0] RST_HINT_PERIOD_MS  = 16'd2000;
   localparam logic [6:0]  RST_WARN_PERCENT    = 7'd10;
   localparam logic [6:0]  RST_BUSY_PERCENT    = 7'd5;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd15;
   localparam logic [TIME_W-1:0]  TIME_ALL_ONES = 32'hFFFF_FFFF;
   localparam int                 PERCENT_FULL = 100;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b000_0001,
      ST_WR_UPD   = 7'b000_0010,
      ST_WR_NEXT  = 7'b000_0100,
      ST_GC_SCAN  = 7'b000_1000,
      ST_GC_DRAIN = 7'b001_0000,
      ST_GC_EVAL  = 7'b010_0000,
      ST_FINISH   = 7'b100_0000
   } state_type;

   typedef struct packed {
      logic load;       // latch the request, start the operation
      logic wr_upd;     // fold the block into the head summary
      logic wr_next;    // open the next segment's summary
      logic scan_step;  // read one zone map entry
      logic gc_eval;    // watermarks, quota and erase
      logic finish;     // hand the result to the output register
   } cmd_type;

   typedef struct packed {
      logic is_gc;
      logic page_full;
      logic scan_last;
      logic out_free;
   } sts_type;

endpackage

// File: sv/fsrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fsrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/fsrm_ctrl.sv
// Sequencer of the flash segment ring manager: one operation at a time.
// Depends on fsrm_pkg; drives the datapath through cmd_type, reads sts_type.
module fsrm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fsrm_pkg::sts_type  sts,
   output fsrm_pkg::cmd_type  cmd
);

   fsrm_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         fsrm_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.is_gc ? fsrm_pkg::ST_GC_SCAN : fsrm_pkg::ST_WR_UPD;
            end
         end
         fsrm_pkg::ST_WR_UPD: begin
            cmd.wr_upd = 1'b1;
            state_in   = sts.page_full ? fsrm_pkg::ST_WR_NEXT : fsrm_pkg::ST_FINISH;
         end
         fsrm_pkg::ST_WR_NEXT: begin
            cmd.wr_next = 1'b1;
            state_in    = fsrm_pkg::ST_FINISH;
         end
         fsrm_pkg::ST_GC_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = fsrm_pkg::ST_GC_DRAIN;
            end
         end
         fsrm_pkg::ST_GC_DRAIN: begin
            state_in = fsrm_pkg::ST_GC_EVAL;
         end
         fsrm_pkg::ST_GC_EVAL: begin
            cmd.gc_eval = 1'b1;
            state_in    = fsrm_pkg::ST_FINISH;
         end
         fsrm_pkg::ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = fsrm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fsrm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsrm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != fsrm_pkg::ST_IDLE);

endmodule

// File: sv/fsrm_dp.sv
// Datapath: head registers, zone map RAM, GC scan, quota logic, result register.
// Depends on fsrm_pkg and fsrm_ram; commanded by fsrm_ctrl.
module fsrm_dp #(
   parameter int SEGMENTS      = 64,
   parameter int DATA_PAGES    = 15,
   parameter int SERIES        = 64,
   parameter int PAGE_BYTES    = 256,
   parameter int SEGMENT_BYTES = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [fsrm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fsrm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  req_kind,
   input  logic [fsrm_pkg::TIME_W-1:0]           req_now_ms,
   input  logic [fsrm_pkg::TIME_W-1:0]           req_start_ms,
   input  logic [fsrm_pkg::TIME_W-1:0]           req_end_ms,
   input  logic [fsrm_pkg::SERIES_ID_W-1:0]      req_series_id,
   input  logic                                  req_no_wait,
   input  fsrm_pkg::cmd_type                     cmd,
   output fsrm_pkg::sts_type                     sts,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [fsrm_pkg::STATUS_W-1:0]         rsp_status,
   output logic [fsrm_pkg::ADDR_W-1:0]           rsp_program_addr,
   output logic                                  rsp_seal_valid,
   output logic [fsrm_pkg::SEG_OUT_W-1:0]        rsp_seal_segment,
   output logic                                  rsp_erase_valid,
   output logic [fsrm_pkg::SEG_OUT_W-1:0]        rsp_erase_segment,
   output logic                                  rsp_hint_valid,
   output logic [fsrm_pkg::ADDR_W-1:0]           rsp_hint_byte_addr,
   output logic [fsrm_pkg::TIME_W-1:0]           rsp_hint_seqno,
   output logic                                  rsp_low_space_warn,
   output logic                                  rsp_low_space_busy
);

   localparam int IW = $clog2(SEGMENTS);
   localparam int CW = $clog2(SEGMENTS + 1);
   localparam int PW = $clog2(DATA_PAGES + 1);
   localparam int MW = CW + fsrm_pkg::PCT_W;
   localparam int TW = fsrm_pkg::TIME_W;
   localparam int KW = fsrm_pkg::COUNT_W;
   localparam int EW = 3 * TW + KW + SERIES;
   localparam int SEQ_HI = EW - 1;
   localparam int MIN_HI = EW - 1 - TW;
   localparam int MAX_HI = EW - 1 - 2 * TW;
   localparam int CNT_HI = SERIES + KW - 1;

   // configuration
   logic [6:0]  cfg_seg_count_ff;
   logic [3:0]  cfg_quota_ff;
   logic [15:0] cfg_qwin_ff;
   logic [15:0] cfg_hint_ff;
   logic [6:0]  cfg_warn_ff;
   logic [6:0]  cfg_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_seg_count_ff <= fsrm_pkg::RST_SEGMENT_COUNT;
         cfg_quota_ff     <= fsrm_pkg::RST_ERASE_QUOTA;
         cfg_qwin_ff      <= fsrm_pkg::RST_QUOTA_WINDOW_MS;
         cfg_hint_ff      <= fsrm_pkg::RST_HINT_PERIOD_MS;
         cfg_warn_ff      <= fsrm_pkg::RST_WARN_PERCENT;
         cfg_busy_ff      <= fsrm_pkg::RST_BUSY_PERCENT;
      end else if (csr_we) begin
         unique case (csr_index)
            fsrm_pkg::CSR_SEGMENT_COUNT:   cfg_seg_count_ff <= csr_wdata[6:0];
            fsrm_pkg::CSR_ERASE_QUOTA:     cfg_quota_ff     <= csr_wdata[3:0];
            fsrm_pkg::CSR_QUOTA_WINDOW_MS: cfg_qwin_ff      <= csr_wdata;
            fsrm_pkg::CSR_HINT_PERIOD_MS:  cfg_hint_ff      <= csr_wdata;
            fsrm_pkg::CSR_WARN_PERCENT:    cfg_warn_ff      <= csr_wdata[6:0];
            fsrm_pkg::CSR_BUSY_PERCENT:    cfg_busy_ff      <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // effective ring size, clamped to 2..SEGMENTS
   logic [CW-1:0] ring_n;
   always_comb begin
      if (cfg_seg_count_ff < 7'd2) begin
         ring_n = CW'(2);
      end else if (32'(cfg_seg_count_ff) > 32'(SEGMENTS)) begin
         ring_n = CW'(SEGMENTS);
      end else begin
         ring_n = CW'(cfg_seg_count_ff);
      end
   end

   function automatic logic [fsrm_pkg::ADDR_W-1:0] addr_of(input logic [IW-1:0] seg,
                                                           input logic [PW-1:0] page);
      logic [31:0] a;
      a = 32'(seg) * 32'(SEGMENT_BYTES) + 32'(page) * 32'(PAGE_BYTES);
      return a[fsrm_pkg::ADDR_W-1:0];
   endfunction

   // latched request
   logic        kind_ff;
   logic [TW-1:0] now_ff, start_ff, end_ff;
   logic [fsrm_pkg::SERIES_ID_W-1:0] series_ff;
   logic        no_wait_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= req_kind;
         now_ff     <= req_now_ms;
         start_ff   <= req_start_ms;
         end_ff     <= req_end_ms;
         series_ff  <= req_series_id;
         no_wait_ff <= req_no_wait;
      end
   end

   // state registers
   logic [IW-1:0] head_seg_ff, head_seg_in;
   logic [PW-1:0] head_page_ff, head_page_in;
   logic [TW-1:0] head_seq_ff, head_seq_in;
   logic [fsrm_pkg::HINT_BLK_W-1:0] blocks_ff, blocks_in;
   logic [TW-1:0] last_hint_ff, last_hint_in;
   logic [TW-1:0] win_start_ff, win_start_in;
   logic [KW-1:0] erased_ff, erased_in;
   logic [TW-1:0] warn_events_ff, warn_events_in;
   logic [TW-1:0] busy_events_ff, busy_events_in;
   logic [SEGMENTS-1:0] seg_valid_ff, seg_valid_in;

   // scan
   logic [IW-1:0] scan_idx_ff, scan_idx_in;
   logic          acc_v_ff;
   logic [IW-1:0] acc_idx_ff;
   logic [CW-1:0] used_ff, used_in;
   logic          found_ff, found_in;
   logic [IW-1:0] oldest_idx_ff, oldest_idx_in;
   logic [TW-1:0] eldest_sn_ff, eldest_sn_in;

   // result being built
   logic [fsrm_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [fsrm_pkg::ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic                          res_seal_v_ff, res_seal_v_in;
   logic [IW-1:0]                 res_seal_seg_ff, res_seal_seg_in;
   logic                          res_erase_v_ff, res_erase_v_in;
   logic [IW-1:0]                 res_erase_seg_ff, res_erase_seg_in;
   logic                          res_warn_ff, res_warn_in;
   logic                          res_busy_ff, res_busy_in;

   // zone map RAM
   logic          ram_we;
   logic [IW-1:0] ram_waddr, ram_raddr;
   logic [EW-1:0] ram_wdata, ram_rdata;

   fsrm_ram #(.WIDTH(EW), .DEPTH(SEGMENTS)) u_zone_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign ram_raddr = cmd.scan_step ? scan_idx_ff : head_seg_ff;

   // write path
   logic [TW-1:0]     e_seq, e_min, e_max;
   logic [KW-1:0]     e_cnt;
   logic [SERIES-1:0] e_map, ser_bit;
   logic [PW-1:0]     page_inc;
   logic [IW-1:0]     next_seg;

   always_comb begin
      if (seg_valid_ff[head_seg_ff]) begin
         e_seq = ram_rdata[SEQ_HI -: TW];
         e_min = ram_rdata[MIN_HI -: TW];
         e_max = ram_rdata[MAX_HI -: TW];
         e_cnt = ram_rdata[CNT_HI -: KW];
         e_map = ram_rdata[SERIES-1:0];
      end else begin
         e_seq = head_seq_ff;
         e_min = fsrm_pkg::TIME_ALL_ONES;
         e_max = '0;
         e_cnt = '0;
         e_map = '0;
      end
      ser_bit  = SERIES'(1) << series_ff;
      page_inc = head_page_ff + PW'(1);
      if ((CW'(head_seg_ff) + CW'(1)) >= ring_n) begin
         next_seg = '0;
      end else begin
         next_seg = head_seg_ff + IW'(1);
      end
   end

   // GC evaluation
   logic [CW-1:0] free_segs;
   logic [MW-1:0] free_scaled, warn_mark, busy_mark;
   logic          below_warn, below_busy;
   logic [TW-1:0] win_elapsed, ws1, ws2;
   logic [KW-1:0] e1;
   logic          quota_hit, busy_nowait;

   always_comb begin
      free_segs   = ring_n - used_ff;
      free_scaled = MW'(free_segs) * MW'(fsrm_pkg::PERCENT_FULL);
      warn_mark   = MW'(cfg_warn_ff) * MW'(ring_n);
      busy_mark   = MW'(cfg_busy_ff) * MW'(ring_n);
      below_warn  = free_scaled < warn_mark;
      below_busy  = free_scaled < busy_mark;
      win_elapsed = now_ff - win_start_ff;
      if (win_elapsed >= TW'(cfg_qwin_ff)) begin
         ws1 = now_ff;
         e1  = '0;
      end else begin
         ws1 = win_start_ff;
         e1  = erased_ff;
      end
      quota_hit   = e1 >= cfg_quota_ff;
      busy_nowait = quota_hit && no_wait_ff;
      ws2         = quota_hit ? ws1 + TW'(cfg_qwin_ff) : ws1;
   end

   // hint
   logic hint_fire;
   assign hint_fire = !kind_ff &&
                      ((blocks_ff == '0) || ((now_ff - last_hint_ff) >= TW'(cfg_hint_ff)));

   always_comb begin
      head_seg_in      = head_seg_ff;
      head_page_in     = head_page_ff;
      head_seq_in      = head_seq_ff;
      blocks_in        = blocks_ff;
      last_hint_in     = last_hint_ff;
      win_start_in     = win_start_ff;
      erased_in        = erased_ff;
      warn_events_in   = warn_events_ff;
      busy_events_in   = busy_events_ff;
      seg_valid_in     = seg_valid_ff;
      scan_idx_in      = scan_idx_ff;
      used_in          = used_ff;
      found_in         = found_ff;
      oldest_idx_in    = oldest_idx_ff;
      eldest_sn_in     = eldest_sn_ff;
      res_status_in    = res_status_ff;
      res_addr_in      = res_addr_ff;
      res_seal_v_in    = res_seal_v_ff;
      res_seal_seg_in  = res_seal_seg_ff;
      res_erase_v_in   = res_erase_v_ff;
      res_erase_seg_in = res_erase_seg_ff;
      res_warn_in      = res_warn_ff;
      res_busy_in      = res_busy_ff;
      ram_we           = 1'b0;
      ram_waddr        = head_seg_ff;
      ram_wdata        = '0;

      if (cmd.load) begin
         scan_idx_in      = '0;
         used_in          = '0;
         found_in         = 1'b0;
         oldest_idx_in    = '0;
         eldest_sn_in     = '0;
         res_status_in    = fsrm_pkg::STATUS_DONE;
         res_addr_in      = '0;
         res_seal_v_in    = 1'b0;
         res_seal_seg_in  = '0;
         res_erase_v_in   = 1'b0;
         res_erase_seg_in = '0;
         res_warn_in      = 1'b0;
         res_busy_in      = 1'b0;
      end

      if (cmd.wr_upd) begin
         res_addr_in               = addr_of(head_seg_ff, head_page_ff);
         blocks_in                 = blocks_ff + fsrm_pkg::HINT_BLK_W'(1);
         seg_valid_in[head_seg_ff] = 1'b1;
         ram_we    = 1'b1;
         ram_waddr = head_seg_ff;
         ram_wdata = {e_seq,
                      (start_ff < e_min) ? start_ff : e_min,
                      (end_ff > e_max) ? end_ff : e_max,
                      (e_cnt < fsrm_pkg::COUNT_MAX) ? e_cnt + KW'(1) : e_cnt,
                      e_map | ser_bit};
         if (32'(page_inc) >= 32'(DATA_PAGES)) begin
            // seal, rotate and open the next segment
            res_seal_v_in          = 1'b1;
            res_seal_seg_in        = head_seg_ff;
            res_erase_v_in         = 1'b1;
            res_erase_seg_in       = next_seg;
            head_seq_in            = head_seq_ff + TW'(1);
            head_seg_in            = next_seg;
            head_page_in           = '0;
            seg_valid_in[next_seg] = 1'b1;
         end else begin
            head_page_in = page_inc;
         end
      end

      if (cmd.wr_next) begin
         ram_we    = 1'b1;
         ram_waddr = head_seg_ff;
         ram_wdata = {head_seq_ff, fsrm_pkg::TIME_ALL_ONES, TW'(0), KW'(0), SERIES'(0)};
      end

      if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + IW'(1);
      end

      if (acc_v_ff && seg_valid_ff[acc_idx_ff] && (ram_rdata[CNT_HI -: KW] != '0)) begin
         used_in = used_ff + CW'(1);
         if (!found_ff || (ram_rdata[SEQ_HI -: TW] < eldest_sn_ff)) begin
            found_in      = 1'b1;
            eldest_sn_in  = ram_rdata[SEQ_HI -: TW];
            oldest_idx_in = acc_idx_ff;
         end
      end

      if (cmd.gc_eval) begin
         res_warn_in    = below_warn;
         res_busy_in    = below_busy;
         warn_events_in = warn_events_ff + TW'(below_warn);
         busy_events_in = busy_events_ff + TW'(below_busy)
                        + TW'(below_warn && busy_nowait);
         if (below_warn) begin
            if (busy_nowait) begin
               win_start_in  = ws1;
               erased_in     = e1;
               res_status_in = fsrm_pkg::STATUS_BUSY;
            end else begin
               win_start_in = ws2;
               erased_in    = quota_hit ? '0 : e1;
               if (found_ff) begin
                  erased_in        = (quota_hit ? '0 : e1) + KW'(1);
                  res_status_in    = fsrm_pkg::STATUS_RECLAIM;
                  res_erase_v_in   = 1'b1;
                  res_erase_seg_in = oldest_idx_ff;
                  ram_we    = 1'b1;
                  ram_waddr = oldest_idx_ff;
                  ram_wdata = {eldest_sn_ff, fsrm_pkg::TIME_ALL_ONES, TW'(0), KW'(0),
                               SERIES'(0)};
               end
            end
         end
      end

      if (cmd.finish && hint_fire) begin
         last_hint_in = now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_seg_ff    <= '0;
         head_page_ff   <= '0;
         head_seq_ff    <= TW'(1);
         blocks_ff      <= '0;
         last_hint_ff   <= '0;
         win_start_ff   <= '0;
         erased_ff      <= '0;
         warn_events_ff <= '0;
         busy_events_ff <= '0;
         seg_valid_ff   <= '0;
         acc_v_ff       <= 1'b0;
      end else begin
         head_seg_ff    <= head_seg_in;
         head_page_ff   <= head_page_in;
         head_seq_ff    <= head_seq_in;
         blocks_ff      <= blocks_in;
         last_hint_ff   <= last_hint_in;
         win_start_ff   <= win_start_in;
         erased_ff      <= erased_in;
         warn_events_ff <= warn_events_in;
         busy_events_ff <= busy_events_in;
         seg_valid_ff   <= seg_valid_in;
         acc_v_ff       <= cmd.scan_step;
      end
   end

   always_ff @(posedge clock) begin
      acc_idx_ff       <= scan_idx_ff;
      scan_idx_ff      <= scan_idx_in;
      used_ff          <= used_in;
      found_ff         <= found_in;
      oldest_idx_ff    <= oldest_idx_in;
      eldest_sn_ff     <= eldest_sn_in;
      res_status_ff    <= res_status_in;
      res_addr_ff      <= res_addr_in;
      res_seal_v_ff    <= res_seal_v_in;
      res_seal_seg_ff  <= res_seal_seg_in;
      res_erase_v_ff   <= res_erase_v_in;
      res_erase_seg_ff <= res_erase_seg_in;
      res_warn_ff      <= res_warn_in;
      res_busy_ff      <= res_busy_in;
   end

   // output register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status         <= res_status_ff;
         rsp_program_addr   <= res_addr_ff;
         rsp_seal_valid     <= res_seal_v_ff;
         rsp_seal_segment   <= fsrm_pkg::SEG_OUT_W'(res_seal_seg_ff);
         rsp_erase_valid    <= res_erase_v_ff;
         rsp_erase_segment  <= fsrm_pkg::SEG_OUT_W'(res_erase_seg_ff);
         rsp_hint_valid     <= hint_fire;
         rsp_hint_byte_addr <= hint_fire ? addr_of(head_seg_ff, head_page_ff) : '0;
         rsp_hint_seqno     <= hint_fire ? head_seq_ff : '0;
         rsp_low_space_warn <= res_warn_ff;
         rsp_low_space_busy <= res_busy_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign sts.is_gc     = (req_kind == fsrm_pkg::KIND_GC);
   assign sts.page_full = 32'(page_inc) >= 32'(DATA_PAGES);
   assign sts.scan_last = (CW'(scan_idx_ff) + CW'(1)) >= ring_n;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

// File: sv/flash_segment_ring_manager_top.sv
// Top level of the flash segment ring manager.
// Depends on fsrm_pkg, fsrm_ctrl, fsrm_dp (and through it fsrm_ram).
//
// The block tracks the head of a flash log ring and a zone map with one
// entry per segment. A write (req_kind 0) returns the page address to
// program, folds the block's time span and series into the head segment's
// summary, and on the last data page seals the segment, rotates the head
// and asks for the erase of the next segment; a head hint is requested every
// 64 blocks or once hint_period_ms has passed. A GC request (req_kind 1)
// scans the ring for used segments, checks the warn and busy watermarks,
// and reclaims the oldest used segment within the per-window erase quota.
// One item is worked on at a time: a write passes through the update
// step, the next-segment step when it seals the segment, and the finish
// step; a GC request passes through the scan, a drain step, the evaluation
// and the finish step, the scan reading one zone map entry per cycle over
// the effective segment count through the single read port of the zone map
// RAM. The finish step registers the result and makes the sequencer idle.
// A finished result waits in the output register while the next item is
// taken in; a result that is still stalled when the next one is done holds
// the sequencer in its last step. The zone map has per-entry valid bits, so
// it needs no clearing pass after reset. Write configuration registers only
// while no item is in flight.
module flash_segment_ring_manager_top #(
   parameter int SEGMENTS      = 64,
   parameter int DATA_PAGES    = 15,
   parameter int SERIES        = 64,
   parameter int PAGE_BYTES    = 256,
   parameter int SEGMENT_BYTES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration writes
   input  logic                              csr_we,
   input  logic [fsrm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fsrm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic [fsrm_pkg::TIME_W-1:0]       req_now_ms,
   input  logic [fsrm_pkg::TIME_W-1:0]       req_start_ms,
   input  logic [fsrm_pkg::TIME_W-1:0]       req_end_ms,
   input  logic [fsrm_pkg::SERIES_ID_W-1:0]  req_series_id,
   input  logic                              req_no_wait,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fsrm_pkg::STATUS_W-1:0]     rsp_status,
   output logic [fsrm_pkg::ADDR_W-1:0]       rsp_program_addr,
   output logic                              rsp_seal_valid,
   output logic [fsrm_pkg::SEG_OUT_W-1:0]    rsp_seal_segment,
   output logic                              rsp_erase_valid,
   output logic [fsrm_pkg::SEG_OUT_W-1:0]    rsp_erase_segment,
   output logic                              rsp_hint_valid,
   output logic [fsrm_pkg::ADDR_W-1:0]       rsp_hint_byte_addr,
   output logic [fsrm_pkg::TIME_W-1:0]       rsp_hint_seqno,
   output logic                              rsp_low_space_warn,
   output logic                              rsp_low_space_busy
);

   fsrm_pkg::cmd_type cmd;
   fsrm_pkg::sts_type sts;

   // sequencer: takes a transfer only when idle, steps through the operation
   fsrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // head state, zone map, GC scan and the output register
   fsrm_dp #(
      .SEGMENTS      (SEGMENTS),
      .DATA_PAGES    (DATA_PAGES),
      .SERIES        (SERIES),
      .PAGE_BYTES    (PAGE_BYTES),
      .SEGMENT_BYTES (SEGMENT_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_kind           (req_kind),
      .req_now_ms         (req_now_ms),
      .req_start_ms       (req_start_ms),
      .req_end_ms         (req_end_ms),
      .req_series_id      (req_series_id),
      .req_no_wait        (req_no_wait),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_program_addr   (rsp_program_addr),
      .rsp_seal_valid     (rsp_seal_valid),
      .rsp_seal_segment   (rsp_seal_segment),
      .rsp_erase_valid    (rsp_erase_valid),
      .rsp_erase_segment  (rsp_erase_segment),
      .rsp_hint_valid     (rsp_hint_valid),
      .rsp_hint_byte_addr (rsp_hint_byte_addr),
      .rsp_hint_seqno     (rsp_hint_seqno),
      .rsp_low_space_warn (rsp_low_space_warn),
      .rsp_low_space_busy (rsp_low_space_busy)
   );

endmodule

// File: sv/fsrm_checker.sv
// Port-level checker for the flash segment ring manager, bound to the top level.
// Depends on fsrm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fsrm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [fsrm_pkg::STATUS_W-1:0]    rsp_status,
   input logic                             rsp_seal_valid,
   input logic                             rsp_erase_valid,
   input logic [fsrm_pkg::ADDR_W-1:0]      rsp_program_addr
);

   `FSRM_ASSERT_HOLD(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp_valid dropped while stalled")
   `FSRM_ASSERT_HOLD(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_status) && $stable(rsp_program_addr), "stalled response changed")
   `FSRM_ASSERT(a_status_code, clock, reset, rsp_valid |-> (rsp_status == fsrm_pkg::STATUS_DONE || rsp_status == fsrm_pkg::STATUS_RECLAIM || rsp_status == fsrm_pkg::STATUS_BUSY), "undefined status code")
   `FSRM_ASSERT(a_seal_erase, clock, reset, (rsp_valid && rsp_seal_valid) |-> rsp_erase_valid, "seal without erase of next segment")
   `FSRM_ASSERT(a_reclaim_erase, clock, reset, (rsp_valid && rsp_status == fsrm_pkg::STATUS_RECLAIM) |-> (rsp_erase_valid && !rsp_seal_valid), "reclaim without erase request")

endmodule

bind flash_segment_ring_manager_top fsrm_checker u_fsrm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_seal_valid   (rsp_seal_valid),
   .rsp_erase_valid  (rsp_erase_valid),
   .rsp_program_addr (rsp_program_addr)
);
